@@ hw/rtl/ihtab_pkg.sv @@
// ----------------------------------------------------------------------------
// ihtab_pkg: shared types and constants of the identifier intern table
// Holds the fixed field widths, the status codes, the back-end state
// encoding and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package ihtab_pkg;

   localparam int CHAR_W     = 8;
   localparam int NAME_CHARS = 8;
   localparam int NAME_W     = CHAR_W * NAME_CHARS;
   localparam int COUNT_W    = 4;
   localparam int SLOT_W     = 10;
   localparam int CHAR_BASE  = 97;

   typedef enum logic [1:0] {
      STATUS_FOUND    = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_COMPARE
   } back_state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } result_type;

endpackage

@@ hw/rtl/identifier_intern_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// identifier_intern_hash_table_core: identifier interning table
// Interns identifier names streamed one character per transaction into an
// open-addressing hash table with linear probing.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one character per transaction in req_tdata[7:0];
// req_tlast marks the final character of an identifier. Characters are
// taken one per cycle while req_tready is high. Only the final character
// produces a result. The rsp channel returns one transaction per
// identifier: the slot that holds the name and a status (found, inserted,
// table full, too long). A finished name is written into a two-entry job
// queue at the edge that accepts its last character. The prober takes each
// probed slot through a registered memory read (ST_LOOK) and a compare
// (ST_COMPARE); an over-long name is answered from ST_IDLE without
// touching the table. A result is loaded only when the output register is
// free, and the prober takes the next name from the queue only once it is
// back in ST_IDLE. After reset the valid bits are swept to zero, one slot
// per cycle across all TABLE_SIZE slots; req_tready stays low during that
// pass. When the receiver stalls, the result waits in the output register
// while the queue keeps absorbing up to two further names; req_tready drops
// when the queue is full, and during the clearing pass.
// ----------------------------------------------------------------------------
module identifier_intern_hash_table_core #(
   parameter int TABLE_SIZE   = 1024,
   parameter int MAX_NAME_LEN = 8
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata fields from bit 0: ch[7:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // rsp_tdata fields from bit 0: slot[9:0], status[11:10], zero fill [15:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata
);
   import ihtab_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int JOB_W = 1 + IDX_W + NAME_W;

   logic               accept;
   logic               job_push;
   logic [NAME_W-1:0]  job_name;
   logic [IDX_W-1:0]   job_hash;
   logic               job_too_long;
   logic               q_push_ready;
   logic               q_pop_valid;
   logic [JOB_W-1:0]   q_pop_data;
   logic               q_pop;
   logic               clearing;
   result_type         result;

   // Characters are refused while the table is cleared and whenever the
   // queue could not take a finished name.
   assign req_tready = q_push_ready && !clearing;
   assign accept     = req_tvalid && req_tready;

   ihtab_front #(
      .TABLE_SIZE   (TABLE_SIZE),
      .MAX_NAME_LEN (MAX_NAME_LEN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ch           (req_tdata[CHAR_W-1:0]),
      .last         (req_tlast),
      .job_push     (job_push),
      .job_name     (job_name),
      .job_hash     (job_hash),
      .job_too_long (job_too_long)
   );

   ihtab_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  ({job_too_long, job_hash, job_name}),
      .push_ready (q_push_ready),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data),
      .pop        (q_pop)
   );

   ihtab_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (q_pop_valid),
      .job_name     (q_pop_data[NAME_W-1:0]),
      .job_hash     (q_pop_data[NAME_W +: IDX_W]),
      .job_too_long (q_pop_data[JOB_W-1]),
      .job_pop      (q_pop),
      .clearing     (clearing),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .result       (result)
   );

   assign rsp_tdata = {4'b0000, result.status, result.slot};

endmodule

@@ hw/rtl/ihtab_ram.sv @@
// ----------------------------------------------------------------------------
// ihtab_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ihtab_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ihtab_queue.sv @@
// ----------------------------------------------------------------------------
// ihtab_queue: two-entry job queue
// Decouples the character front end from the probing back end.
// ----------------------------------------------------------------------------
module ihtab_queue #(
   parameter int WIDTH = 81
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   input  logic             pop
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/ihtab_front.sv @@
// ----------------------------------------------------------------------------
// ihtab_front: character accumulator
// Packs characters into a name word, counts them and keeps the additive
// hash; on the final character it hands a complete job to the queue.
// ----------------------------------------------------------------------------
module ihtab_front #(
   parameter int TABLE_SIZE   = 1024,
   parameter int MAX_NAME_LEN = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [ihtab_pkg::CHAR_W-1:0]      ch,
   input  logic                              last,
   output logic                              job_push,
   output logic [ihtab_pkg::NAME_W-1:0]      job_name,
   output logic [$clog2(TABLE_SIZE)-1:0]     job_hash,
   output logic                              job_too_long
);
   import ihtab_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);

   logic [IDX_W-1:0]   delta_tab [256];
   logic [NAME_W-1:0]  name_ff;
   logic [NAME_W-1:0]  name_in;
   logic [NAME_W-1:0]  name_next;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_next;
   logic [IDX_W-1:0]   hash_ff;
   logic [IDX_W-1:0]   hash_in;
   logic [IDX_W-1:0]   hash_next;
   logic [IDX_W:0]     hash_sum;

   // Per-character hash step (ch - 'a') reduced modulo the table size.
   for (genvar i = 0; i < 256; i++) begin : g_delta
      localparam int unsigned DELTA =
         ((i % TABLE_SIZE) + TABLE_SIZE - (CHAR_BASE % TABLE_SIZE)) % TABLE_SIZE;
      assign delta_tab[i] = DELTA[IDX_W-1:0];
   end

   always_comb begin
      name_next  = name_ff;
      count_next = count_ff;
      if (count_ff < COUNT_W'(MAX_NAME_LEN)) begin
         for (int k = 0; k < NAME_CHARS; k++) begin
            if (count_ff == COUNT_W'(k)) begin
               name_next[k*CHAR_W +: CHAR_W] = name_ff[k*CHAR_W +: CHAR_W] | ch;
            end
         end
         count_next = count_ff + COUNT_W'(1);
      end else begin
         count_next = COUNT_W'(MAX_NAME_LEN + 1);
      end

      hash_sum = {1'b0, hash_ff} + {1'b0, delta_tab[ch]};
      if (hash_sum >= (IDX_W+1)'(TABLE_SIZE)) begin
         hash_next = IDX_W'(hash_sum - (IDX_W+1)'(TABLE_SIZE));
      end else begin
         hash_next = hash_sum[IDX_W-1:0];
      end

      name_in  = name_ff;
      count_in = count_ff;
      hash_in  = hash_ff;
      if (accept) begin
         if (last) begin
            name_in  = '0;
            count_in = '0;
            hash_in  = '0;
         end else begin
            name_in  = name_next;
            count_in = count_next;
            hash_in  = hash_next;
         end
      end
   end

   assign job_push     = accept && last;
   assign job_name     = name_next;
   assign job_hash     = hash_next;
   assign job_too_long = (count_next > COUNT_W'(MAX_NAME_LEN));

   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff  <= '0;
         count_ff <= '0;
         hash_ff  <= '0;
      end else begin
         name_ff  <= name_in;
         count_ff <= count_in;
         hash_ff  <= hash_in;
      end
   end

endmodule

@@ hw/rtl/ihtab_back.sv @@
// ----------------------------------------------------------------------------
// ihtab_back: table prober
// Clears the valid bits after reset, then takes jobs from the queue and
// probes the table linearly from the hash slot, a read and a compare per probe.
// ----------------------------------------------------------------------------
module ihtab_back #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  logic [ihtab_pkg::NAME_W-1:0]  job_name,
   input  logic [$clog2(TABLE_SIZE)-1:0] job_hash,
   input  logic                          job_too_long,
   output logic                          job_pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ihtab_pkg::result_type         result
);
   import ihtab_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [IDX_W-1:0]    clr_idx_ff;
   logic [IDX_W-1:0]    clr_idx_in;
   logic [IDX_W-1:0]    probe_idx_ff;
   logic [IDX_W-1:0]    probe_idx_in;
   logic [IDX_W-1:0]    probe_cnt_ff;
   logic [IDX_W-1:0]    probe_cnt_in;
   logic [NAME_W-1:0]   name_ff;
   logic [NAME_W-1:0]   name_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   result_type          result_ff;
   result_type          result_in;
   logic                out_free;
   logic                insert;
   logic                rsp_load;
   logic [IDX_W:0]      idx_inc;
   logic [IDX_W-1:0]    idx_wrap;
   logic [IDX_W+SLOT_W-1:0] idx_ext;
   logic [NAME_W-1:0]   name_rd;
   logic                valid_rd;
   logic                valid_wr_en;
   logic [IDX_W-1:0]    valid_wr_addr;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_inc  = {1'b0, probe_idx_ff} + (IDX_W+1)'(1);
   assign idx_wrap = (probe_idx_ff == LAST_IDX) ? '0 : idx_inc[IDX_W-1:0];
   assign idx_ext  = {{SLOT_W{1'b0}}, probe_idx_ff};

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      probe_idx_in = probe_idx_ff;
      probe_cnt_in = probe_cnt_ff;
      name_in      = name_ff;
      result_in    = result_ff;
      rsp_load     = 1'b0;
      insert       = 1'b0;
      job_pop      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               if (job_too_long) begin
                  if (out_free) begin
                     job_pop   = 1'b1;
                     rsp_load  = 1'b1;
                     result_in = '{slot: '0, status: STATUS_TOO_LONG};
                  end
               end else begin
                  job_pop      = 1'b1;
                  name_in      = job_name;
                  probe_idx_in = job_hash;
                  probe_cnt_in = '0;
                  state_in     = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (!valid_rd) begin
               if (out_free) begin
                  insert    = 1'b1;
                  rsp_load  = 1'b1;
                  result_in = '{slot: idx_ext[SLOT_W-1:0], status: STATUS_INSERTED};
                  state_in  = ST_IDLE;
               end
            end else if (name_rd == name_ff) begin
               if (out_free) begin
                  rsp_load  = 1'b1;
                  result_in = '{slot: idx_ext[SLOT_W-1:0], status: STATUS_FOUND};
                  state_in  = ST_IDLE;
               end
            end else if (probe_cnt_ff == LAST_IDX) begin
               if (out_free) begin
                  rsp_load  = 1'b1;
                  result_in = '{slot: '0, status: STATUS_FULL};
                  state_in  = ST_IDLE;
               end
            end else begin
               probe_idx_in = idx_wrap;
               probe_cnt_in = probe_cnt_ff + IDX_W'(1);
               state_in     = ST_LOOK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign valid_wr_en   = insert || (state_ff == ST_CLEAR);
   assign valid_wr_addr = (state_ff == ST_CLEAR) ? clr_idx_ff : probe_idx_ff;

   ihtab_ram #(
      .WIDTH (NAME_W),
      .DEPTH (TABLE_SIZE)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (insert),
      .wr_addr (probe_idx_ff),
      .wr_data (name_ff),
      .rd_addr (probe_idx_ff),
      .rd_data (name_rd)
   );

   ihtab_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_SIZE)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_wr_en),
      .wr_addr (valid_wr_addr),
      .wr_data (insert),
      .rd_addr (probe_idx_ff),
      .rd_data (valid_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         probe_idx_ff <= '0;
         probe_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         probe_idx_ff <= probe_idx_in;
         probe_cnt_ff <= probe_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff   <= name_in;
      result_ff <= result_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   // No job leaves the queue while the valid bits are being swept.
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !job_pop)
      else $error("job taken during clearing pass");

   // A new result is only loaded when the output register is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while stalled");

   // A name is written only into a slot read as empty.
   a_insert_empty: assert property (@(posedge clock) disable iff (reset)
      insert |-> ((state_ff == ST_COMPARE) && !valid_rd))
      else $error("insert into an occupied slot");

   // An address issue is always followed by the compare cycle.
   a_look_compare: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> (state_ff == ST_COMPARE))
      else $error("probe sequence broken");

   // Popping requires a job to be present.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("pop from empty queue");

endmodule

@@ tb/identifier_intern_hash_table_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// identifier_intern_hash_table_core_test: self-checking bench for the intern table
// Streams identifiers into the table one character per transaction, predicts
// the slot and status of every identifier with a behavioral copy of the table
// and compares each response transaction field by field. A directed table
// comes first, then random names under three idle patterns.
// ----------------------------------------------------------------------------
module identifier_intern_hash_table_core_test;
   import ihtab_pkg::*;

   localparam int TABLE_SLOTS = 1024;
   localparam int NAME_LIMIT = 8;
   // Characters of random names sent in each of the three idle patterns.
   localparam int CHARS_PER_PHASE = 134;
   // Cycles allowed after the last response for a stray transaction to show.
   localparam int SETTLE_CYCLES = 16;

   // One row of the directed table. Where typed is set, slot and status are
   // the expected answer written by hand; otherwise the predictor decides.
   typedef struct packed {
      logic [7:0]        ch;
      logic              last;
      logic              typed;
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } directed_row_type;

   // Every block input holds a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // ch[7:0]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // slot[9:0], status[11:10], zero fill [15:12]

   // Percent of cycles in which the sender holds back or the receiver stalls.
   int send_idle_pct = 34;
   int take_idle_pct = 50;
   int mismatch_count = 0;

   // Behavioral copy of the table and of the name being collected.
   logic [NAME_W-1:0] interned_names [TABLE_SLOTS];
   bit                slot_taken [TABLE_SLOTS];
   logic [NAME_W-1:0] partial_name = '0;
   int unsigned       partial_len = 0;
   logic [SLOT_W-1:0] partial_hash = '0;

   // Answers still owed by the block, oldest first.
   result_type awaited_answers [$];
   // Characters of the identifier about to be sent.
   logic [7:0] name_chars [$];
   // Names sent so far that fit the length limit, kept for repeat lookups.
   logic [NAME_W-1:0] sent_words [$];
   int                sent_lens [$];

   identifier_intern_hash_table_core #(
      .TABLE_SIZE  (TABLE_SLOTS),
      .MAX_NAME_LEN(NAME_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Takes one character into the predicted state. On the final character it
   // resolves the identifier against the table and returns 1 with the answer.
   function automatic bit intern_char(input logic [7:0] ch, input logic last_flag,
                                      output result_type answer);
      logic [SLOT_W-1:0] probe;
      answer.slot = '0;
      answer.status = STATUS_FOUND;
      // Characters past the limit are not stored; the count sticks one above
      // the limit so the name is reported as too long.
      if (partial_len < NAME_LIMIT) begin
         partial_name = partial_name | (NAME_W'(ch) << (8 * partial_len));
         partial_len++;
      end else begin
         partial_len = NAME_LIMIT + 1;
      end
      // The hash is kept as a 10-bit residue, so subtracting the base of the
      // alphabet wraps instead of going negative.
      partial_hash = partial_hash + SLOT_W'(ch) - SLOT_W'(CHAR_BASE);
      if (!last_flag)
         return 1'b0;
      if (partial_len > NAME_LIMIT) begin
         answer.status = STATUS_TOO_LONG;
      end else begin
         // Linear probe from the hash slot, wrapping past the top slot. If the
         // loop runs out, every slot is taken by some other name.
         answer.status = STATUS_FULL;
         probe = partial_hash;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!slot_taken[probe]) begin
               slot_taken[probe] = 1'b1;
               interned_names[probe] = partial_name;
               answer.slot = probe;
               answer.status = STATUS_INSERTED;
               break;
            end
            if (interned_names[probe] == partial_name) begin
               answer.slot = probe;
               answer.status = STATUS_FOUND;
               break;
            end
            probe = probe + 1'b1;
         end
      end
      partial_name = '0;
      partial_len = 0;
      partial_hash = '0;
      return 1'b1;
   endfunction

   // Offers one character, idling first at the current rate, and waits for
   // the handshake. The prediction is taken once the block has accepted it.
   task automatic send_char(input logic [7:0] ch, input logic last_flag,
                            output bit produced, output result_type answer);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last_flag;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      produced = intern_char(ch, last_flag, answer);
   endtask

   // Sends the identifier held in name_chars and queues its predicted answer.
   task automatic send_name();
      bit                produced;
      result_type        answer;
      logic [NAME_W-1:0] word;
      word = '0;
      for (int k = 0; k < name_chars.size(); k++) begin
         send_char(name_chars[k], k == name_chars.size() - 1, produced, answer);
         if (produced)
            awaited_answers.push_back(answer);
         if (k < NAME_LIMIT)
            word[8*k +: 8] = name_chars[k];
      end
      if (name_chars.size() <= NAME_LIMIT) begin
         sent_words.push_back(word);
         sent_lens.push_back(name_chars.size());
      end
   endtask

   // Picks the next identifier. A share of the names repeat an earlier one,
   // which exercises lookups that hit after colliding neighbors. New names
   // are mostly short so that hashes cluster and probes run past several
   // slots; some are longer than the limit. Half the characters are lower
   // case letters, the rest any nonzero byte.
   function automatic void pick_name(input int repeat_pct);
      int roll;
      int len;
      int pick;
      name_chars.delete();
      if ($urandom_range(99) < repeat_pct && sent_words.size() != 0) begin
         pick = $urandom_range(sent_words.size() - 1);
         for (int k = 0; k < sent_lens[pick]; k++)
            name_chars.push_back(sent_words[pick][8*k +: 8]);
         return;
      end
      roll = $urandom_range(99);
      if (roll < 10)
         len = $urandom_range(12, NAME_LIMIT + 1);
      else if (roll < 60)
         len = $urandom_range(3, 1);
      else
         len = $urandom_range(NAME_LIMIT, 1);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(1))
            name_chars.push_back(8'($urandom_range(122, 97)));
         else
            name_chars.push_back(8'($urandom_range(255, 1)));
      end
   endfunction

   task automatic send_random_names(input int char_budget);
      int sent_chars = 0;
      while (sent_chars < char_budget) begin
         pick_name(15);
         sent_chars += name_chars.size();
         send_name();
      end
   endtask

   // Holds the sender off until every owed answer has come back. Since every
   // identifier ends with a final character, the block is then idle.
   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      while (awaited_answers.size() != 0)
         @(posedge clock);
   endtask

   // Response side: every accepted transaction is checked against the oldest
   // owed answer, and the ready line is redrawn at the current stall rate.
   always @(posedge clock) begin : response_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: response with none owed, expected nothing, actual slot %0d status %0d",
                     $time, rsp_tdata[SLOT_W-1:0], rsp_tdata[SLOT_W+1:SLOT_W]);
            mismatch_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_tdata[SLOT_W-1:0] !== want.slot) begin
               $display("%0t: slot mismatch, expected %0d, actual %0d",
                        $time, want.slot, rsp_tdata[SLOT_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[SLOT_W+1:SLOT_W] !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_tdata[SLOT_W+1:SLOT_W]);
               mismatch_count++;
            end
            if (rsp_tdata[15:SLOT_W+2] !== '0) begin
               $display("%0t: fill bits mismatch, expected 0, actual %0h",
                        $time, rsp_tdata[15:SLOT_W+2]);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= take_idle_pct);
   end

   initial begin
      directed_row_type plan [$];
      bit               produced;
      result_type       answer;
      result_type       typed_answer;

      // Directed table. Typed answers follow from the hash alone: a single
      // character c hashes to c - 'a' modulo the table size.
      plan = '{
         // "a" lands on slot 0 right after reset, then is found there.
         {8'h61, 1'b1, 1'b1, 10'd0,    STATUS_INSERTED},
         {8'h61, 1'b1, 1'b1, 10'd0,    STATUS_FOUND},
         // "b" takes slot 1; "ab" also hashes to 1 and moves on to slot 2.
         {8'h62, 1'b1, 1'b1, 10'd1,    STATUS_INSERTED},
         {8'h61, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h62, 1'b1, 1'b1, 10'd2,    STATUS_INSERTED},
         // A character below 'a' wraps the hash to the top slot.
         {8'h60, 1'b1, 1'b1, 10'd1023, STATUS_INSERTED},
         // "a`" also hashes to the top slot, so the probe wraps to slot 0
         // and walks past the names in slots 0 to 2.
         {8'h61, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h60, 1'b1, 1'b1, 10'd3,    STATUS_INSERTED},
         // Largest and smallest character values.
         {8'hFF, 1'b1, 1'b1, 10'd158,  STATUS_INSERTED},
         {8'h01, 1'b1, 1'b1, 10'd928,  STATUS_INSERTED},
         // Nine characters: one past the limit, answered without a probe.
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h7A, 1'b1, 1'b1, 10'd0,    STATUS_TOO_LONG},
         // Exactly the limit, all ones: hash 8 * 158 wraps to 240.
         {8'hFF, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'hFF, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'hFF, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'hFF, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'hFF, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'hFF, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'hFF, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'hFF, 1'b1, 1'b1, 10'd240,  STATUS_INSERTED},
         // A zero byte is hashed and counted but packs as nothing.
         {8'h61, 1'b0, 1'b0, 10'd0,    STATUS_FOUND},
         {8'h00, 1'b1, 1'b0, 10'd0,    STATUS_FOUND}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its valid bits after reset with ready low; the
      // first handshake simply waits that pass out.
      foreach (plan[r]) begin
         send_char(plan[r].ch, plan[r].last, produced, answer);
         if (produced) begin
            if (plan[r].typed) begin
               typed_answer.slot = plan[r].slot;
               typed_answer.status = plan[r].status;
               awaited_answers.push_back(typed_answer);
            end else begin
               awaited_answers.push_back(answer);
            end
         end
      end

      // Random names: sender idles a third of the time, receiver half.
      send_random_names(CHARS_PER_PHASE);
      wait_for_answers();

      // The other way round.
      send_idle_pct = 50;
      take_idle_pct = 34;
      send_random_names(CHARS_PER_PHASE);
      wait_for_answers();

      // Back to back on both sides.
      send_idle_pct = 0;
      take_idle_pct = 0;
      send_random_names(CHARS_PER_PHASE);

      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Run limit, several times the slowest correct run, even if every name
   // probed all occupied slots under the longest stalls.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
